FILE: rtl/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the sequential list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sle_pkg;

   localparam int CAPACITY_DEFAULT = 256;
   localparam int FUNC_W           = 2;
   localparam int POS_W            = 9;
   localparam int VAL_W            = 32;
   localparam int STAT_W           = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_LOCATE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      func_type               func;
      logic [POS_W-1:0]       position;
      logic signed [VAL_W-1:0] item_value;
   } req_type;

   typedef struct packed {
      status_type              status;
      logic signed [VAL_W-1:0] removed_value;
      logic [POS_W-1:0]        found_position;
      logic [POS_W-1:0]        list_length;
   } rsp_type;

endpackage

FILE: rtl/sle_ram.sv
// ----------------------------------------------------------------------------
// sle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/sle_core.sv
// ----------------------------------------------------------------------------
// sle_core
// Sequencer and index unit: range checks, entry shifts and search, one
// memory read and one memory write step at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sle_core #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  sle_pkg::req_type req,
   output logic             req_ready,
   output logic             res_valid,
   output sle_pkg::rsp_type res,
   input  logic             res_take
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

   typedef enum logic [7:0] {
      ST_IDLE = 8'b0000_0001,
      ST_GET  = 8'b0000_0010,
      ST_TAKE = 8'b0000_0100,
      ST_RD   = 8'b0000_1000,
      ST_WR   = 8'b0001_0000,
      ST_CMP  = 8'b0010_0000,
      ST_FIN  = 8'b0100_0000,
      ST_DONE = 8'b1000_0000
   } state_type;

   state_type                       state_ff, state_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic [CW-1:0]                   idx_ff, idx_in;
   sle_pkg::func_type               op_ff, op_in;
   logic [sle_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic signed [sle_pkg::VAL_W-1:0] val_ff, val_in;
   sle_pkg::status_type             status_ff, status_in;
   logic signed [sle_pkg::VAL_W-1:0] removed_ff, removed_in;
   logic [sle_pkg::POS_W-1:0]       found_ff, found_in;

   logic [EW-1:0] count_e, idx_e, idx_m1, idx_p1, pos_e, pos_ff_e, pos_m1, cap_e;

   logic                        wr_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [sle_pkg::VAL_W-1:0]   wr_data, rd_data;

   assign count_e  = {{(EW-CW){1'b0}}, count_ff};
   assign idx_e    = {{(EW-CW){1'b0}}, idx_ff};
   assign idx_m1   = idx_e - EW'(1);
   assign idx_p1   = idx_e + EW'(1);
   assign pos_e    = {{(EW-sle_pkg::POS_W){1'b0}}, req.position};
   assign pos_ff_e = {{(EW-sle_pkg::POS_W){1'b0}}, pos_ff};
   assign pos_m1   = pos_ff_e - EW'(1);
   assign cap_e    = EW'(CAPACITY);

   sle_ram #(
      .WIDTH (sle_pkg::VAL_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // memory port steering
   always_comb begin
      rd_addr = idx_e[AW-1:0];
      wr_addr = idx_e[AW-1:0];
      wr_data = rd_data;
      wr_en   = 1'b0;
      case (state_ff)
         ST_GET: begin
            rd_addr = pos_m1[AW-1:0];
         end
         ST_RD: begin
            if (op_ff == sle_pkg::FUNC_INSERT) begin
               rd_addr = idx_m1[AW-1:0];
            end
         end
         ST_WR: begin
            wr_en = 1'b1;
            if (op_ff == sle_pkg::FUNC_DELETE) begin
               wr_addr = idx_m1[AW-1:0];
            end
         end
         ST_FIN: begin
            if (op_ff == sle_pkg::FUNC_INSERT) begin
               wr_en   = 1'b1;
               wr_addr = pos_m1[AW-1:0];
               wr_data = val_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      op_in      = op_ff;
      pos_in     = pos_ff;
      val_in     = val_ff;
      status_in  = status_ff;
      removed_in = removed_ff;
      found_in   = found_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in      = req.func;
               pos_in     = req.position;
               val_in     = req.item_value;
               status_in  = sle_pkg::STAT_OK;
               removed_in = '0;
               found_in   = '0;
               case (req.func)
                  sle_pkg::FUNC_INSERT: begin
                     if (pos_e == '0 || pos_e > count_e + EW'(1)) begin
                        status_in = sle_pkg::STAT_RANGE;
                        state_in  = ST_DONE;
                     end else if (count_e >= cap_e) begin
                        status_in = sle_pkg::STAT_FULL;
                        state_in  = ST_DONE;
                     end else begin
                        idx_in   = count_ff;
                        state_in = (count_e >= pos_e) ? ST_RD : ST_FIN;
                     end
                  end
                  sle_pkg::FUNC_DELETE: begin
                     if (pos_e == '0 || pos_e > count_e) begin
                        status_in = sle_pkg::STAT_RANGE;
                        state_in  = ST_DONE;
                     end else begin
                        state_in = ST_GET;
                     end
                  end
                  sle_pkg::FUNC_LOCATE: begin
                     idx_in   = '0;
                     state_in = (count_ff == '0) ? ST_DONE : ST_RD;
                  end
                  sle_pkg::FUNC_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_GET: begin
            state_in = ST_TAKE;
         end
         ST_TAKE: begin
            removed_in = rd_data;
            if (pos_ff_e < count_e) begin
               idx_in   = pos_ff_e[CW-1:0];
               state_in = ST_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_RD: begin
            state_in = (op_ff == sle_pkg::FUNC_LOCATE) ? ST_CMP : ST_WR;
         end
         ST_WR: begin
            if (op_ff == sle_pkg::FUNC_INSERT) begin
               idx_in   = idx_m1[CW-1:0];
               state_in = (idx_m1 >= pos_ff_e) ? ST_RD : ST_FIN;
            end else begin
               idx_in   = idx_p1[CW-1:0];
               state_in = (idx_p1 < count_e) ? ST_RD : ST_FIN;
            end
         end
         ST_CMP: begin
            if (rd_data == val_ff) begin
               found_in = idx_p1[sle_pkg::POS_W-1:0];
               state_in = ST_DONE;
            end else if (idx_p1 < count_e) begin
               idx_in   = idx_p1[CW-1:0];
               state_in = ST_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_FIN: begin
            if (op_ff == sle_pkg::FUNC_INSERT) begin
               count_in = count_ff + CW'(1);
            end else begin
               count_in = count_ff - CW'(1);
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff     <= idx_in;
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign res_valid          = (state_ff == ST_DONE);
   assign res.status         = status_ff;
   assign res.removed_value  = removed_ff;
   assign res.found_position = found_ff;
   assign res.list_length    = count_e[sle_pkg::POS_W-1:0];

endmodule

FILE: rtl/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit elements with insert, delete, locate, clear.
// ----------------------------------------------------------------------------
// One request at a time: req_tready is high only while the engine is idle.
// Clear and rejected requests go straight from idle to the done state. The
// sequencer steps through the store one entry at a time: each shifted entry
// of an insert or delete takes a read state and then a write state, and each
// compared entry of a locate a read state and then a compare state. A delete
// first fetches the removed entry; insert and delete end in a finish state
// that updates the length, and for an insert writes the new item. A finished
// result sits in an output register while the next request is taken.
`timescale 1ns / 1ps

module sequential_list_engine #(
   parameter int CAPACITY = sle_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // position[8:0], item_value[40:9], zero
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // removed_value[31:0], found_position[40:32],
                                   // list_length[49:41], zero
   output logic [1:0]  rsp_tuser   // status[1:0]
);

   sle_pkg::req_type req;
   sle_pkg::rsp_type res;
   sle_pkg::rsp_type rsp_data_ff;
   logic             rsp_valid_ff;
   logic             res_valid;
   logic             res_take;

   assign req.func       = sle_pkg::func_type'(req_tuser);
   assign req.position   = req_tdata[8:0];
   assign req.item_value = req_tdata[40:9];

   sle_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (res_take) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {6'd0, rsp_data_ff.list_length, rsp_data_ff.found_position,
                        rsp_data_ff.removed_value};

endmodule
